[rtl/clwv_pkg.sv]
// ----------------------------------------------------------------------------
// clwv_pkg - shared types and constants for the contact link window vote
// Window geometry, field widths and the slot word carried along the cell chain.
// ----------------------------------------------------------------------------
package clwv_pkg;

    localparam int WINDOW_LEN   = 20;
    localparam int JOINT_COUNT  = 7;
    localparam int INPUT_JOINTS = 7;
    localparam int DET_JOINTS   = (JOINT_COUNT < INPUT_JOINTS) ? JOINT_COUNT : INPUT_JOINTS;

    localparam int RES_W  = 16;
    localparam int MAG_W  = RES_W + 1;
    localparam int THR_W  = 15;
    localparam int LINK_W = 4;
    localparam int HIT_W  = $clog2(WINDOW_LEN + 1);
    localparam int IN_W   = INPUT_JOINTS * RES_W;
    localparam int OUT_W  = 8;

    localparam logic [THR_W-1:0]  THRESH_RESET = THR_W'(77);
    localparam logic [LINK_W-1:0] LINK_NONE    = 4'hF;

    // one window slot: a verdict that holds a link, or none
    typedef struct packed {
        logic              valid;
        logic [LINK_W-1:0] link;
    } slot_t;

endpackage

[rtl/clwv_cell.sv]
// ----------------------------------------------------------------------------
// clwv_cell - one slot of the verdict window
// Holds one verdict and hands it to the next cell on every accepted word.
// ----------------------------------------------------------------------------
module clwv_cell
    import clwv_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  shift_en,
    input  slot_t slot_in,
    output slot_t slot_out
);

    logic              valid_reg;
    logic [LINK_W-1:0] link_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= slot_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            link_reg <= slot_in.link;
        end
    end

    assign slot_out.valid = valid_reg;
    assign slot_out.link  = link_reg;

endmodule

[rtl/clwv_detect.sv]
// ----------------------------------------------------------------------------
// clwv_detect - instantaneous link detection
// Compares each joint's absolute residual with the threshold and picks the
// highest joint over it.
// ----------------------------------------------------------------------------
module clwv_detect
    import clwv_pkg::*;
(
    input  logic [IN_W-1:0]  residuals,
    input  logic [THR_W-1:0] threshold,
    output slot_t            verdict
);

    logic [DET_JOINTS-1:0] over;

    always_comb begin
        logic [RES_W-1:0] raw;
        logic [MAG_W-1:0] mag;
        for (int j = 0; j < DET_JOINTS; j++) begin
            raw = residuals[j*RES_W +: RES_W];
            // most negative value maps to 32768, no wrap
            mag = raw[RES_W-1] ? (MAG_W'(1 << RES_W) - {1'b0, raw}) : {1'b0, raw};
            over[j] = mag > MAG_W'(threshold);
        end
    end

    always_comb begin
        verdict.valid = 1'b0;
        verdict.link  = '0;
        for (int j = 0; j < DET_JOINTS; j++) begin
            if (over[j]) begin
                verdict.valid = 1'b1;
                verdict.link  = LINK_W'(j);
            end
        end
    end

endmodule

[rtl/contact_link_window_vote.sv]
// ----------------------------------------------------------------------------
// contact_link_window_vote - debounced contact link detection
// Threshold detection per joint, sliding verdict window and hit-count vote.
// ----------------------------------------------------------------------------
// One residual word is accepted per cycle unless the output stalls; its result
// word appears in the output register on the following cycle. The window is a
// shift chain of WINDOW_LEN cells moved once per word, with a running
// occupancy count and per-link hit counters updated in the same cycle and a
// compare chain over the JOINT_COUNT counters feeding the output register.
// Contact turns on when all slots hold a link and off when all are empty;
// while on, the reported link is the most frequent one, ties to the lowest.
// ----------------------------------------------------------------------------
module contact_link_window_vote
    import clwv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // residual_j0 .. residual_j6, 16 bits each, from the lowest bit up
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // contact_on [0], contact_link [4:1], contact_lost [5], zero pad
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  logic [THR_W-1:0] cfg_data,
    input  logic             cfg_valid,
    output logic             cfg_ready
);

    logic [THR_W-1:0]  thresh_reg;
    logic [HIT_W-1:0]  occ_reg, occ_next;
    logic [HIT_W-1:0]  hits_reg  [JOINT_COUNT];
    logic [HIT_W-1:0]  hits_next [JOINT_COUNT];
    logic              contact_reg, contact_next;
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;
    logic              accept;
    slot_t             verdict;
    slot_t             chain [WINDOW_LEN+1];
    slot_t             oldest;
    logic [WINDOW_LEN-1:0] win_valid;
    logic [LINK_W-1:0] best_link, out_link;
    logic [HIT_W-1:0]  best_cnt;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thresh_reg <= cfg_data;
        end
    end

    clwv_detect u_detect (
        .residuals (s_tdata),
        .threshold (thresh_reg),
        .verdict   (verdict)
    );

    assign chain[0] = verdict;

    for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
        clwv_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (accept),
            .slot_in  (chain[i]),
            .slot_out (chain[i+1])
        );
        assign win_valid[i] = chain[i+1].valid;
    end

    // the last cell holds the verdict that leaves the window on this word
    assign oldest = chain[WINDOW_LEN];

    always_comb begin
        for (int j = 0; j < JOINT_COUNT; j++) begin
            hits_next[j] = hits_reg[j];
            if (oldest.valid && oldest.link == LINK_W'(j) && hits_reg[j] != '0) begin
                hits_next[j] = hits_next[j] - HIT_W'(1);
            end
            if (verdict.valid && verdict.link == LINK_W'(j)) begin
                hits_next[j] = hits_next[j] + HIT_W'(1);
            end
        end
        occ_next = occ_reg - HIT_W'(oldest.valid) + HIT_W'(verdict.valid);
    end

    always_comb begin
        if (occ_next == HIT_W'(WINDOW_LEN)) begin
            contact_next = 1'b1;
        end else if (occ_next == '0) begin
            contact_next = 1'b0;
        end else begin
            contact_next = contact_reg;
        end
    end

    // strict compare keeps ties on the lowest link
    always_comb begin
        best_link = '0;
        best_cnt  = hits_next[0];
        for (int j = 1; j < JOINT_COUNT; j++) begin
            if (hits_next[j] > best_cnt) begin
                best_link = LINK_W'(j);
                best_cnt  = hits_next[j];
            end
        end
    end

    always_comb begin
        if (contact_next) begin
            out_link = best_link;
        end else if (verdict.valid) begin
            out_link = verdict.link;
        end else begin
            out_link = LINK_NONE;
        end
        m_data_next = {2'b00, contact_reg && !contact_next, out_link, contact_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            contact_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < JOINT_COUNT; j++) begin
                hits_reg[j] <= '0;
            end
        end else begin
            if (accept) begin
                occ_reg     <= occ_next;
                contact_reg <= contact_next;
                for (int j = 0; j < JOINT_COUNT; j++) begin
                    hits_reg[j] <= hits_next[j];
                end
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_occ_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(win_valid) == 32'(occ_reg))
        else $error("occupancy count differs from valid cells");

    a_occ_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= HIT_W'(WINDOW_LEN))
        else $error("occupancy count above window length");

    a_contact_needs_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        contact_reg |-> occ_reg != '0)
        else $error("contact held with an empty window");

    a_lost_clears_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[5]) |-> !m_data_reg[0])
        else $error("lost pulse with contact still on");

    a_on_has_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[0]) |-> m_data_reg[4:1] != LINK_NONE)
        else $error("contact on without a link");
`endif

endmodule

[verif/tb_contact_link_window_vote.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contact_link_window_vote - self-checking bench for the contact link vote
// Streams residual words into the block and predicts each result word: the
// per-joint threshold test, the verdict window, the hit-count vote and the
// lost-contact pulse. Covers threshold extremes, edge residuals, contact and
// release sequences, random idling on both sides and long receiver stalls.
// ----------------------------------------------------------------------------
module tb_contact_link_window_vote;
    import clwv_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 180;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic              on;
        logic [LINK_W-1:0] link;
        logic              lost;
    } vote_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [THR_W-1:0] cfg_data  = '0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;

    logic [IN_W-1:0] residual_q[$];
    vote_t           vote_q[$];
    int              mismatches    = 0;
    int              cycle_cnt     = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              hold_seq      = 0;
    int              hold_seen     = 0;
    int              hold_left     = 0;

    // predictor state
    logic [THR_W-1:0]  thresh_model = THRESH_RESET;
    logic              win_valid[WINDOW_LEN];
    logic [LINK_W-1:0] win_link[WINDOW_LEN];
    int                hit_cnt[JOINT_COUNT];
    int                win_pos    = 0;
    logic              contact_st = 1'b0;

    contact_link_window_vote u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic vote_t predict_vote(logic [IN_W-1:0] vec);
        int                cur;
        int                r;
        int                mag;
        int                occ;
        int                best;
        logic              found;
        logic              was_on;
        logic [LINK_W-1:0] det;
        vote_t             v;
        cur    = win_pos;
        was_on = contact_st;
        found  = 1'b0;
        det    = LINK_NONE;
        if (win_valid[cur] && win_link[cur] < JOINT_COUNT && hit_cnt[win_link[cur]] > 0)
            hit_cnt[win_link[cur]]--;
        for (int j = 0; j < DET_JOINTS; j++) begin
            r   = $signed(vec[j*RES_W +: RES_W]);
            mag = (r < 0) ? -r : r;
            if (mag > int'(thresh_model)) begin
                found = 1'b1;
                det   = LINK_W'(j);
            end
        end
        win_valid[cur] = found;
        win_link[cur]  = found ? det : '0;
        if (found)
            hit_cnt[det]++;
        occ = 0;
        for (int i = 0; i < WINDOW_LEN; i++)
            occ += win_valid[i];
        if (occ == WINDOW_LEN)
            contact_st = 1'b1;
        else if (occ == 0)
            contact_st = 1'b0;
        if (contact_st) begin
            best = 0;
            for (int j = 1; j < JOINT_COUNT; j++)
                if (hit_cnt[j] > hit_cnt[best])
                    best = j;
            det   = LINK_W'(best);
            found = 1'b1;
        end
        v.on    = contact_st;
        v.link  = found ? det : LINK_NONE;
        v.lost  = was_on && !contact_st;
        win_pos = (cur + 1) % WINDOW_LEN;
        return v;
    endfunction

    function automatic logic [IN_W-1:0] uniform(logic [RES_W-1:0] v);
        return {INPUT_JOINTS{v}};
    endfunction

    // magnitude at or under the threshold, equality now and then
    function automatic logic [RES_W-1:0] quiet_residual(int thr);
        int m;
        if ($urandom_range(4) == 0)
            m = thr;
        else
            m = $urandom_range(thr, 0);
        return ($urandom_range(1) && m != 0) ? RES_W'(-m) : RES_W'(m);
    endfunction

    function automatic logic [RES_W-1:0] loud_residual(int thr);
        int m;
        if (thr >= 32767)
            return 16'h8000;
        case ($urandom_range(3))
            0: m = thr + 1;
            1: m = 32768;
            default: m = $urandom_range(32768, thr + 1);
        endcase
        if (m == 32768)
            return 16'h8000;
        return $urandom_range(1) ? RES_W'(-m) : RES_W'(m);
    endfunction

    // lnk < 0 means no joint over threshold
    function automatic logic [IN_W-1:0] make_vector(int lnk, int thr);
        logic [IN_W-1:0] vec;
        for (int j = 0; j < INPUT_JOINTS; j++) begin
            if (lnk < 0 || j > lnk)
                vec[j*RES_W +: RES_W] = quiet_residual(thr);
            else if (j == lnk)
                vec[j*RES_W +: RES_W] = loud_residual(thr);
            else
                vec[j*RES_W +: RES_W] = $urandom_range(1) ? RES_W'($urandom)
                                                          : quiet_residual(thr);
        end
        return vec;
    endfunction

    task automatic fill_random(int n, int thr);
        int added;
        int len;
        int a;
        int b;
        int lnk;
        logic [IN_W-1:0] vec;
        added = 0;
        while (added < n) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    // detection run, two links competing for the vote
                    len = $urandom_range(40, 5);
                    a   = $urandom_range(JOINT_COUNT - 1);
                    b   = $urandom_range(JOINT_COUNT - 1);
                    for (int k = 0; k < len; k++) begin
                        lnk = $urandom_range(1) ? a : b;
                        if ($urandom_range(11) == 0)
                            lnk = $urandom_range(JOINT_COUNT - 1);
                        residual_q = {residual_q, make_vector(lnk, thr)};
                    end
                end
                5, 6, 7: begin
                    len = $urandom_range(35, 5);
                    for (int k = 0; k < len; k++)
                        residual_q = {residual_q, make_vector(-1, thr)};
                end
                8: begin
                    len = $urandom_range(15, 3);
                    for (int k = 0; k < len; k++)
                        residual_q = {residual_q,
                                      make_vector(int'($urandom_range(JOINT_COUNT)) - 1, thr)};
                end
                default: begin
                    len = $urandom_range(6, 1);
                    for (int k = 0; k < len; k++) begin
                        for (int j = 0; j < INPUT_JOINTS; j++)
                            vec[j*RES_W +: RES_W] = RES_W'($urandom);
                        residual_q = {residual_q, vec};
                    end
                end
            endcase
            added += len;
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (residual_q.size() != 0 || s_tvalid || vote_q.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid    <= 1'b0;
        thresh_model = v;
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                vote_q = {vote_q, predict_vote(s_tdata)};
            if (s_tvalid && !s_tready) begin
                // word still waiting, hold it
            end else if (residual_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= residual_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver hold-off counter
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        vote_t exp_v;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (vote_q.size() == 0) begin
                    $display("%0t: result word expected none actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    exp_v = vote_q.pop_front();
                    // contact_on [0], contact_link [4:1], contact_lost [5]
                    if (m_tdata[0] !== exp_v.on) begin
                        $display("%0t: contact_on expected %0d actual %0d",
                                 $time, exp_v.on, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[4:1] !== exp_v.link) begin
                        $display("%0t: contact_link expected %h actual %h",
                                 $time, exp_v.link, m_tdata[4:1]);
                        mismatches++;
                    end
                    if (m_tdata[5] !== exp_v.lost) begin
                        $display("%0t: contact_lost expected %0d actual %0d",
                                 $time, exp_v.lost, m_tdata[5]);
                        mismatches++;
                    end
                end
            end
            if (hold_seq != hold_seen || hold_left > 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** contact_link_window_vote: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [IN_W-1:0]  vec;
        logic [THR_W-1:0] thr;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            win_valid[i] = 1'b0;
            win_link[i]  = '0;
        end
        for (int j = 0; j < JOINT_COUNT; j++)
            hit_cnt[j] = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words at the reset threshold of 77
        residual_q = {residual_q, IN_W'(0)};
        residual_q = {residual_q, uniform(16'd77)};
        residual_q = {residual_q, uniform(16'hFFB3)};
        residual_q = {residual_q, uniform(16'd78)};
        for (int j = 0; j < INPUT_JOINTS; j++) begin
            vec = '0;
            vec[j*RES_W +: RES_W] = (j % 2) ? 16'hFFB2 : 16'd78;
            residual_q = {residual_q, vec};
        end
        // most negative residual must not wrap
        vec = uniform(16'hFFB3);
        vec[3*RES_W +: RES_W] = 16'h8000;
        residual_q = {residual_q, vec};
        residual_q = {residual_q, uniform(16'h7FFF)};
        residual_q = {residual_q, uniform(16'h8000)};
        residual_q = {residual_q, uniform(16'hAAAA)};
        residual_q = {residual_q, uniform(16'h5555)};
        vec = '0;
        vec[6*RES_W +: RES_W] = 16'h7FFF;
        vec[2*RES_W +: RES_W] = 16'h8000;
        residual_q = {residual_q, vec};
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: thr = '0;
                1: thr = 15'h7FFF;
                2: thr = 15'd256;
                3: thr = THR_W'($urandom_range(32767, 0));
                4: thr = 15'd1;
                default: thr = THRESH_RESET;
            endcase
            write_threshold(thr);
            @(negedge aclk);
            send_idle_pct = (p < 2) ? 15 : (p < 4) ? 53 : 0;
            recv_idle_pct = (p < 2) ? 53 : (p < 4) ? 15 : 0;
            fill_random(PHASE_WORDS, int'(thr));
            // long receiver stall with the sender still pushing
            if (p == 1 || p == 4)
                hold_seq = hold_seq + 1;
            wait_idle();
        end

        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("** contact_link_window_vote: PASSED **");
        else
            $display("** contact_link_window_vote: FAILED **");
        $finish;
    end

endmodule
